// ===== rtl/multi_string_hash_engine_unit_macros.svh =====
// Assertion macros shared by the string hash engine RTL.
// Included by every module that carries concurrent assertions.
`ifndef MULTI_STRING_HASH_ENGINE_UNIT_MACROS_SVH
`define MULTI_STRING_HASH_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MSH_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msh assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msh assertion failed");

`endif

// ===== rtl/msh_pkg.sv =====
// Types and constants for the multi string hash engine.
// No dependencies; used by msh_core and multi_string_hash_engine_unit.
`timescale 1ns / 1ps

package msh_pkg;

   localparam logic [31:0] RS_B_MULT   = 32'd378551;
   localparam logic [31:0] RS_A_INIT   = 32'd63689;
   localparam logic [31:0] JS_INIT     = 32'd1315423911;
   localparam logic [31:0] DJB_INIT    = 32'd5381;
   localparam logic [31:0] AP_INIT     = 32'hAAAAAAAA;
   localparam logic [31:0] NIBBLE_HIGH = 32'hF0000000;
   localparam logic [31:0] WORD_MASK   = 32'hFFFFFFFF;

   // RS multiplier after the first byte of a string
   localparam logic [63:0] RS_MULT_PROD = 64'(RS_A_INIT) * 64'(RS_B_MULT);
   localparam logic [31:0] RS_MULT_AFTER_FIRST = RS_MULT_PROD[31:0] & WORD_MASK;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic        last_byte;
      logic [31:0] string_length;
   } req_type;

   typedef struct packed {
      logic [31:0] rs_hash;
      logic [31:0] js_hash;
      logic [31:0] pjw_hash;
      logic [31:0] elf_hash;
      logic [31:0] bkdr_hash;
      logic [31:0] sdbm_hash;
      logic [31:0] dek_hash;
      logic [31:0] djb_hash;
      logic [31:0] ap_hash;
   } rsp_type;

   typedef struct packed {
      logic absorb;
      logic reload;
   } ctrl_type;

endpackage

// ===== rtl/msh_core.sv =====
// Hash state registers and the one-byte update of all nine hashes.
// Depends on msh_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "multi_string_hash_engine_unit_macros.svh"

module msh_core (
   input  logic              clock,
   input  logic              reset,
   input  msh_pkg::ctrl_type ctrl,
   input  logic [7:0]        data_byte,
   input  logic [31:0]       string_length,
   output msh_pkg::rsp_type  hash_in
);

   msh_pkg::rsp_type hash_ff;
   msh_pkg::rsp_type base;
   logic [31:0]      rs_mult_ff;
   logic [31:0]      rs_mult_in;
   logic [31:0]      rs_mult_base;
   logic             odd_ff;
   logic             odd_base;
   logic [31:0]      c;
   logic [31:0]      rs_prod;
   logic [31:0]      ap_prod;
   logic [31:0]      pjw_h;
   logic [31:0]      pjw_t;
   logic [31:0]      elf_h;
   logic [31:0]      elf_t;
   logic [31:0]      ap_h;

   always_comb begin
      c = {{24{data_byte[7]}}, data_byte};
      if (ctrl.reload) begin
         base.rs_hash   = '0;
         base.js_hash   = msh_pkg::JS_INIT;
         base.pjw_hash  = '0;
         base.elf_hash  = '0;
         base.bkdr_hash = '0;
         base.sdbm_hash = '0;
         base.dek_hash  = string_length;
         base.djb_hash  = msh_pkg::DJB_INIT;
         base.ap_hash   = msh_pkg::AP_INIT;
         rs_mult_base   = msh_pkg::RS_A_INIT;
         odd_base       = 1'b0;
      end else begin
         base         = hash_ff;
         rs_mult_base = rs_mult_ff;
         odd_base     = odd_ff;
      end

      rs_prod    = base.rs_hash * rs_mult_base;
      rs_mult_in = rs_mult_base * msh_pkg::RS_B_MULT;
      ap_h       = base.ap_hash;
      ap_prod    = c * (ap_h >> 3);

      hash_in.rs_hash = rs_prod + c;
      hash_in.js_hash = base.js_hash
                      ^ ((base.js_hash << 5) + c + (base.js_hash >> 2));

      // fold the high nibble back into the low bits
      pjw_h = (base.pjw_hash << 4) + c;
      pjw_t = pjw_h & msh_pkg::NIBBLE_HIGH;
      if (pjw_t != '0) begin
         pjw_h = (pjw_h ^ (pjw_t >> 24)) & ~msh_pkg::NIBBLE_HIGH;
      end
      hash_in.pjw_hash = pjw_h;

      elf_h = (base.elf_hash << 4) + c;
      elf_t = elf_h & msh_pkg::NIBBLE_HIGH;
      if (elf_t != '0) begin
         elf_h = elf_h ^ (elf_t >> 24);
      end
      hash_in.elf_hash = elf_h & ~elf_t;

      hash_in.bkdr_hash = (base.bkdr_hash << 7) + (base.bkdr_hash << 1)
                        + base.bkdr_hash + c;
      hash_in.sdbm_hash = c + (base.sdbm_hash << 6) + (base.sdbm_hash << 16)
                        - base.sdbm_hash;
      hash_in.dek_hash  = ((base.dek_hash << 5) ^ (base.dek_hash >> 27)) ^ c;
      hash_in.djb_hash  = (base.djb_hash << 5) + base.djb_hash + c;

      if (!odd_base) begin
         hash_in.ap_hash = ap_h ^ (ap_h << 7) ^ ap_prod;
      end else begin
         hash_in.ap_hash = ap_h ^ ~((ap_h << 11) + (c ^ (ap_h >> 5)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff.rs_hash   <= '0;
         hash_ff.js_hash   <= msh_pkg::JS_INIT;
         hash_ff.pjw_hash  <= '0;
         hash_ff.elf_hash  <= '0;
         hash_ff.bkdr_hash <= '0;
         hash_ff.sdbm_hash <= '0;
         hash_ff.dek_hash  <= '0;
         hash_ff.djb_hash  <= msh_pkg::DJB_INIT;
         hash_ff.ap_hash   <= msh_pkg::AP_INIT;
         rs_mult_ff        <= msh_pkg::RS_A_INIT;
         odd_ff            <= 1'b0;
      end else if (ctrl.absorb) begin
         hash_ff    <= hash_in;
         rs_mult_ff <= rs_mult_in;
         odd_ff     <= ~odd_base;
      end
   end

   `MSH_ASSERT_NEXT(a_idle_holds_state, clock, reset, !ctrl.absorb, $stable(hash_ff) && $stable(rs_mult_ff))
   `MSH_ASSERT_NEXT(a_reload_restarts, clock, reset, ctrl.absorb && ctrl.reload, odd_ff && (rs_mult_ff == msh_pkg::RS_MULT_AFTER_FIRST))
   `MSH_ASSERT_NEXT(a_parity_toggles, clock, reset, ctrl.absorb && !ctrl.reload, odd_ff != $past(odd_ff))

endmodule

// ===== rtl/multi_string_hash_engine_unit.sv =====
// Top level of the multi string hash engine: input register, result register, handshakes.
// Depends on msh_pkg, msh_core and the shared assertion macros.
`timescale 1ns / 1ps
`include "multi_string_hash_engine_unit_macros.svh"

// Streams a string one byte per item and keeps the RS, JS, PJW, ELF, BKDR, SDBM,
// DEK, DJB and AP hashes of it; each byte is taken as a signed char. Set first_byte
// on a string's first byte (string_length then seeds DEK) and last_byte on its final
// byte, which returns one item with all nine hashes. One byte is taken every cycle; the
// input stalls only while a last byte waits behind an undelivered, stalled result. A
// result is registered as its last byte leaves the input register. The rate is set by
// the hash state loop, whose deepest path is the 32x32 RS and AP multiplies.
module multi_string_hash_engine_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  msh_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output msh_pkg::rsp_type rsp_payload
);

   logic              in_valid_ff;
   logic              in_valid_in;
   msh_pkg::req_type  in_payload_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   msh_pkg::rsp_type  rsp_payload_ff;
   msh_pkg::rsp_type  hash_in;
   msh_pkg::ctrl_type ctrl;
   logic              advance;
   logic              req_take;
   logic              rsp_take;

   always_comb begin
      // a non-last byte never needs the result register
      advance = in_valid_ff
             && (!in_payload_ff.last_byte || !rsp_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !advance;
      req_take  = req_valid && !req_stall;
      rsp_take  = rsp_valid_ff && !rsp_stall;

      ctrl.absorb = advance;
      ctrl.reload = in_payload_ff.first_byte;

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && in_payload_ff.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   msh_core u_core (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .data_byte     (in_payload_ff.data_byte),
      .string_length (in_payload_ff.string_length),
      .hash_in       (hash_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_payload_ff <= req_payload;
      end
      if (advance && in_payload_ff.last_byte) begin
         rsp_payload_ff <= hash_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `MSH_ASSERT_IMP(a_stall_only_on_blocked_last, clock, reset, req_stall, in_valid_ff && in_payload_ff.last_byte && rsp_valid_ff)
   `MSH_ASSERT_NEXT(a_last_fills_result, clock, reset, advance && in_payload_ff.last_byte, rsp_valid_ff)
   `MSH_ASSERT_NEXT(a_blocked_item_held, clock, reset, req_stall, in_valid_ff && $stable(in_payload_ff))

endmodule

// ===== tb/sv/tb_multi_string_hash_engine_unit.sv =====
// Self-checking bench for multi_string_hash_engine_unit: byte streams in, nine hashes out.
// Predicts every hash from its own running state and checks results in order.
// Depends on msh_pkg for payload types and hash constants.
`timescale 1ns / 1ps

module tb_multi_string_hash_engine_unit;

   localparam logic [31:0] BKDR_SEED = 32'd131;
   localparam int IDLE_PCT = 17;
   localparam int HOLD_CYCLES = 300;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   msh_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   msh_pkg::rsp_type rsp_payload;

   multi_string_hash_engine_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   msh_pkg::req_type pending_bytes[$];
   msh_pkg::rsp_type expected_hashes[$];

   // running hashes of the string in progress
   msh_pkg::rsp_type hash_state;
   logic [31:0]      rs_step_mult;
   logic             ap_odd;

   int error_count = 0;
   int results_seen = 0;
   int cycle_count = 0;
   int hold_left = 0;
   int holds_done = 0;
   logic [287:0] want_bits;
   logic [287:0] got_bits;
   string hash_label [9] = '{"rs_hash", "js_hash", "pjw_hash", "elf_hash", "bkdr_hash",
                             "sdbm_hash", "dek_hash", "djb_hash", "ap_hash"};

   // no random idling on either side inside this window
   wire quiet = (cycle_count >= 1500) && (cycle_count < 2200);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void reload_hashes(logic [31:0] dek_seed);
      hash_state.rs_hash   = '0;
      hash_state.js_hash   = msh_pkg::JS_INIT;
      hash_state.pjw_hash  = '0;
      hash_state.elf_hash  = '0;
      hash_state.bkdr_hash = '0;
      hash_state.sdbm_hash = '0;
      hash_state.dek_hash  = dek_seed;
      hash_state.djb_hash  = msh_pkg::DJB_INIT;
      hash_state.ap_hash   = msh_pkg::AP_INIT;
      rs_step_mult = msh_pkg::RS_A_INIT;
      ap_odd = 1'b0;
   endfunction

   function automatic void absorb_byte(logic [7:0] b);
      logic [31:0] c;
      logic [31:0] h;
      logic [31:0] t;
      c = {{24{b[7]}}, b};
      hash_state.rs_hash = hash_state.rs_hash * rs_step_mult + c;
      rs_step_mult = rs_step_mult * msh_pkg::RS_B_MULT;
      h = hash_state.js_hash;
      hash_state.js_hash = h ^ ((h << 5) + c + (h >> 2));
      // fold the high nibble back in once it fills
      h = (hash_state.pjw_hash << 4) + c;
      t = h & msh_pkg::NIBBLE_HIGH;
      if (t != 0) h = (h ^ (t >> 24)) & ~msh_pkg::NIBBLE_HIGH;
      hash_state.pjw_hash = h;
      h = (hash_state.elf_hash << 4) + c;
      t = h & msh_pkg::NIBBLE_HIGH;
      if (t != 0) h = h ^ (t >> 24);
      hash_state.elf_hash = h & ~t;
      hash_state.bkdr_hash = hash_state.bkdr_hash * BKDR_SEED + c;
      h = hash_state.sdbm_hash;
      hash_state.sdbm_hash = c + (h << 6) + (h << 16) - h;
      h = hash_state.dek_hash;
      hash_state.dek_hash = (h << 5) ^ (h >> 27) ^ c;
      h = hash_state.djb_hash;
      hash_state.djb_hash = (h << 5) + h + c;
      h = hash_state.ap_hash;
      if (!ap_odd) h = h ^ (h << 7) ^ (c * (h >> 3));
      else h = h ^ ~((h << 11) + (c ^ (h >> 5)));
      hash_state.ap_hash = h;
      ap_odd = ~ap_odd;
   endfunction

   function automatic void take_byte(msh_pkg::req_type item);
      if (item.first_byte) reload_hashes(item.string_length);
      absorb_byte(item.data_byte);
      if (item.last_byte) expected_hashes.push_back(hash_state);
   endfunction

   function automatic msh_pkg::req_type make_item(logic [7:0] b, logic f, logic l,
                                                  logic [31:0] n);
      msh_pkg::req_type item;
      item.data_byte = b;
      item.first_byte = f;
      item.last_byte = l;
      item.string_length = n;
      return item;
   endfunction

   // Mostly well-formed strings; a tenth get random first/last flags.
   task automatic queue_random_strings(int byte_budget);
      int pushed;
      int len;
      int kind;
      logic [31:0] n;
      logic f;
      logic l;
      pushed = 0;
      while (pushed < byte_budget) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
         kind = $urandom_range(99);
         n = (kind < 80) ? 32'(len) : 32'($urandom);
         for (int i = 0; i < len; i++) begin
            f = (i == 0);
            l = (i == len - 1);
            if (kind >= 90) begin
               f = 1'($urandom_range(1));
               l = ($urandom_range(3) == 0);
            end
            pending_bytes.push_back(make_item(8'($urandom), f, l, n));
         end
         pushed += len;
      end
   endtask

   task automatic drain_results();
      while (pending_bytes.size() != 0 || req_valid || expected_hashes.size() != 0)
         @(posedge clock);
   endtask

   // Driver: advance to the next item once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) take_byte(req_payload);
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_payload <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random, plus two long hold-offs to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && results_seen >= 40 + 110 * holds_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Monitor: compare every delivered item against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_bits = rsp_payload;
         if (expected_hashes.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, got_bits);
            error_count++;
         end else begin
            want_bits = expected_hashes.pop_front();
            for (int k = 0; k < 9; k++) begin
               if (got_bits[287 - 32 * k -: 32] !== want_bits[287 - 32 * k -: 32]) begin
                  $display("%0t: %s expected %h, got %h", $time, hash_label[k],
                           want_bits[287 - 32 * k -: 32], got_bits[287 - 32 * k -: 32]);
                  error_count++;
               end
            end
         end
         results_seen <= results_seen + 1;
      end
   end

   initial begin
      reload_hashes(32'd0);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // continue from the reset values without a first flag
      pending_bytes.push_back(make_item(8'h61, 1'b0, 1'b0, 32'hDEADBEEF));
      pending_bytes.push_back(make_item(8'h80, 1'b0, 1'b1, 32'h00000000));
      // one-byte strings at the extremes
      pending_bytes.push_back(make_item(8'h00, 1'b1, 1'b1, 32'd1));
      pending_bytes.push_back(make_item(8'hFF, 1'b1, 1'b1, 32'hFFFFFFFF));
      pending_bytes.push_back(make_item(8'h7F, 1'b1, 1'b1, 32'd0));
      pending_bytes.push_back(make_item(8'h80, 1'b1, 1'b1, 32'h80000000));
      pending_bytes.push_back(make_item(8'h68, 1'b1, 1'b0, 32'd5));
      pending_bytes.push_back(make_item(8'h65, 1'b0, 1'b0, 32'd5));
      pending_bytes.push_back(make_item(8'h6C, 1'b0, 1'b0, 32'd5));
      pending_bytes.push_back(make_item(8'h6C, 1'b0, 1'b0, 32'd5));
      pending_bytes.push_back(make_item(8'h6F, 1'b0, 1'b1, 32'd5));
      // length that does not match the byte count; long enough to fold the high nibble
      for (int i = 0; i < 9; i++)
         pending_bytes.push_back(make_item(8'hFF, i == 0, i == 8, 32'd3));
      // keep hashing past a last byte
      pending_bytes.push_back(make_item(8'h41, 1'b0, 1'b1, 32'd0));
      // drop an unfinished string
      pending_bytes.push_back(make_item(8'h01, 1'b1, 1'b0, 32'd2));
      pending_bytes.push_back(make_item(8'h02, 1'b1, 1'b1, 32'd7));
      drain_results();

      queue_random_strings(1000);
      drain_results();
      queue_random_strings(1000);
      drain_results();
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
